@@ rtl/toroidal_life_automaton_assert.svh @@
// ----------------------------------------------------------------------------
// toroidal_life_automaton_assert.svh
// assertion macros for the life automaton, clocked on aclk, reset by aresetn
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_AUTOMATON_ASSERT_SVH
`define TOROIDAL_LIFE_AUTOMATON_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TLA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TLA_ASSERT_IMP(label, ante, cons, msg)
`define TLA_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/tla_pkg.sv @@
// ----------------------------------------------------------------------------
// tla_pkg
// shared types and constants of the toroidal life automaton
// ----------------------------------------------------------------------------
`default_nettype none

package tla_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2
    } tla_cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_STEP,
        S_DONE
    } tla_state_t;

    // one column of the three-row window held by a cell
    typedef struct packed {
        logic up;
        logic mid;
        logic dn;
    } tla_col_t;

    // per-cycle controls broadcast to the cell row
    typedef struct packed {
        logic shift;
        logic capture;
        logic use_first;
    } tla_cell_ctl_t;

    typedef logic [3:0] tla_count_t;

    localparam tla_count_t SURVIVE_COUNT = 4'd2;
    localparam tla_count_t BIRTH_COUNT   = 4'd3;

endpackage

`default_nettype wire

@@ rtl/tla_ram.sv @@
// ----------------------------------------------------------------------------
// tla_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tla_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/tla_cell.sv @@
// ----------------------------------------------------------------------------
// tla_cell
// one column of the generation sweep: a three-row window and the b3/s23 rule
// ----------------------------------------------------------------------------
`default_nettype none

module tla_cell
    import tla_pkg::*;
(
    input  wire logic          clk,
    input  tla_cell_ctl_t      ctl,
    input  wire logic          in_bit,
    input  tla_col_t           left,
    input  tla_col_t           right,
    output tla_col_t           col,
    output logic               next_bit
);

    logic       up_reg;
    logic       mid_reg;
    logic       dn_reg;
    logic       first_reg;
    logic       feed;
    tla_count_t count;

    // the first row is overwritten early in the sweep, so keep its old value
    assign feed = ctl.use_first ? first_reg : in_bit;

    always_ff @(posedge clk) begin
        if (ctl.shift) begin
            up_reg  <= mid_reg;
            mid_reg <= dn_reg;
            dn_reg  <= feed;
        end
        if (ctl.capture) begin
            first_reg <= in_bit;
        end
    end

    assign col.up  = up_reg;
    assign col.mid = mid_reg;
    assign col.dn  = dn_reg;

    assign count = {3'b000, left.up}  + {3'b000, left.mid}  + {3'b000, left.dn}
                 + {3'b000, right.up} + {3'b000, right.mid} + {3'b000, right.dn}
                 + {3'b000, up_reg}   + {3'b000, dn_reg};

    assign next_bit = (count == BIRTH_COUNT) || (mid_reg && (count == SURVIVE_COUNT));

endmodule

`default_nettype wire

@@ rtl/toroidal_life_automaton.sv @@
// ----------------------------------------------------------------------------
// toroidal_life_automaton
// conway life (b3/s23) on a wrapped grid, driven by write, read and step commands
// ----------------------------------------------------------------------------
// The grid lives in a ram of GRID_HEIGHT rows of GRID_WIDTH bits. After reset
// a clearing pass writes every row dead, while s_ready stays low. A write or
// read goes from transfer to result through a ram read, then read-modify-write
// or bit select, then the output register. A step sweeps the grid through a
// row of GRID_WIDTH cells that each hold a three-row window of their column
// and share it with both neighbors; the single ram read port feeds one row
// per cycle. One command is in work at a time; the next is taken while the
// previous result waits in the output register. Command code 3 changes
// nothing and returns done_res 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toroidal_life_automaton_assert.svh"

module toroidal_life_automaton
    import tla_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [5:0] s_col,
    input  wire logic [5:0] s_row,
    input  wire logic       s_cell_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_cell_out,
    output logic            m_done_res
);

    localparam int ROW_W = $clog2(GRID_HEIGHT);
    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int CNT_W = $clog2(GRID_HEIGHT + 4);

    tla_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    tla_cmd_t               cmd_reg, cmd_next;
    logic [5:0]             col_reg, col_next;
    logic [5:0]             row_reg, row_next;
    logic                   val_reg, val_next;
    logic                   inside_reg, inside_next;
    logic                   res_cell_reg, res_cell_next;
    logic                   res_done_reg, res_done_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_cell_out_reg, m_cell_out_next;
    logic                   m_done_res_reg, m_done_res_next;

    logic [15:0]            s_col_ext, s_row_ext, col_ext, row_ext;
    logic [COL_W-1:0]       col_idx;
    logic [ROW_W-1:0]       row_idx, s_row_idx;
    logic [CNT_W-1:0]       cnt_m1, cnt_m4;
    logic                   s_inside;

    logic                   ram_we;
    logic [ROW_W-1:0]       ram_waddr, ram_raddr;
    logic [GRID_WIDTH-1:0]  ram_wdata, ram_rdata, mod_row, new_row;

    tla_cell_ctl_t          cell_ctl;
    tla_col_t               col_bus [GRID_WIDTH];

    // ------------------------------------------------------------------------
    // index handling
    // ------------------------------------------------------------------------
    assign s_col_ext = {10'b0, s_col};
    assign s_row_ext = {10'b0, s_row};
    assign col_ext   = {10'b0, col_reg};
    assign row_ext   = {10'b0, row_reg};
    assign col_idx   = col_ext[COL_W-1:0];
    assign row_idx   = row_ext[ROW_W-1:0];
    assign s_row_idx = s_row_ext[ROW_W-1:0];
    assign s_inside  = (s_col_ext < 16'(GRID_WIDTH)) && (s_row_ext < 16'(GRID_HEIGHT));
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cnt_m4    = cnt_reg - CNT_W'(4);

    // ------------------------------------------------------------------------
    // grid storage
    // ------------------------------------------------------------------------
    tla_ram #(
        .DATA_W (GRID_WIDTH),
        .DEPTH  (GRID_HEIGHT)
    ) u_grid (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        mod_row          = ram_rdata;
        mod_row[col_idx] = val_reg;
    end

    // sweep order: last row, then rows 0 .. last; the wrap to row 0 comes from the cells
    always_comb begin
        if (state_reg == S_STEP) begin
            ram_raddr = (cnt_reg == '0) ? ROW_W'(GRID_HEIGHT - 1) : cnt_m1[ROW_W-1:0];
        end else begin
            ram_raddr = s_row_idx;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[ROW_W-1:0];
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_ACCESS: begin
                ram_we    = (cmd_reg == CMD_WRITE) && inside_reg;
                ram_waddr = row_idx;
                ram_wdata = mod_row;
            end
            S_STEP: begin
                // window is centered on row cnt-4 once three rows have been shifted in
                ram_we    = (cnt_reg >= CNT_W'(4));
                ram_waddr = cnt_m4[ROW_W-1:0];
                ram_wdata = new_row;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------------
    assign cell_ctl.shift     = (state_reg == S_STEP) && (cnt_reg >= CNT_W'(1))
                              && (cnt_reg <= CNT_W'(GRID_HEIGHT + 2));
    assign cell_ctl.capture   = (state_reg == S_STEP) && (cnt_reg == CNT_W'(2));
    assign cell_ctl.use_first = (cnt_reg == CNT_W'(GRID_HEIGHT + 2));

    for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_cell
        localparam int LEFT  = (c == 0) ? GRID_WIDTH - 1 : c - 1;
        localparam int RIGHT = (c == GRID_WIDTH - 1) ? 0 : c + 1;

        tla_cell u_cell (
            .clk      (aclk),
            .ctl      (cell_ctl),
            .in_bit   (ram_rdata[c]),
            .left     (col_bus[LEFT]),
            .right    (col_bus[RIGHT]),
            .col      (col_bus[c]),
            .next_bit (new_row[c])
        );
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        val_reg        <= val_next;
        inside_reg     <= inside_next;
        res_cell_reg   <= res_cell_next;
        res_done_reg   <= res_done_next;
        m_cell_out_reg <= m_cell_out_next;
        m_done_res_reg <= m_done_res_next;
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        val_next        = val_reg;
        inside_next     = inside_reg;
        res_cell_next   = res_cell_reg;
        res_done_next   = res_done_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_out_next = m_cell_out_reg;
        m_done_res_next = m_done_res_reg;
        s_ready         = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(GRID_HEIGHT - 1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next      = tla_cmd_t'(s_command);
                    col_next      = s_col;
                    row_next      = s_row;
                    val_next      = s_cell_in;
                    inside_next   = s_inside;
                    res_cell_next = 1'b0;
                    res_done_next = 1'b1;
                    cnt_next      = '0;
                    case (tla_cmd_t'(s_command))
                        CMD_WRITE: state_next = S_ACCESS;
                        CMD_READ:  state_next = S_ACCESS;
                        CMD_STEP:  state_next = S_STEP;
                        default: begin
                            res_done_next = 1'b0;
                            state_next    = S_DONE;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                if (cmd_reg == CMD_READ) begin
                    res_cell_next = inside_reg && ram_rdata[col_idx];
                end
                state_next = S_DONE;
            end
            S_STEP: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(GRID_HEIGHT + 3)) begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_cell_out_next = res_cell_reg;
                    m_done_res_next = res_done_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_out_reg;
    assign m_done_res = m_done_res_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `TLA_ASSERT_IMP(a_step_rw_apart, (state_reg == S_STEP) && ram_we, ram_waddr != ram_raddr, "sweep writes the row it reads")
    `TLA_ASSERT_NXT(a_one_in_work, s_valid && s_ready, !s_ready, "second transfer taken while busy")
    `TLA_ASSERT_IMP(a_clear_quiet, state_reg == S_CLEAR, !m_valid_reg && !s_ready, "traffic during clearing pass")
    `TLA_ASSERT_IMP(a_unused_zero, m_valid_reg && !m_done_res_reg, !m_cell_out_reg, "unused command returned a cell")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the toroidal life automaton
// ----------------------------------------------------------------------------
// Drives write, read, step and unused commands through the valid/ready input
// channel. A scoreboard keeps its own copy of the wrapped grid, predicts the
// result of every accepted command and compares each result transfer in
// order. Directed commands hit the grid corners and a blinker that wraps
// across both edges. Random traffic is mostly bursts of writes into a small
// window, a few generations, then reads back of the same window. Both sides
// stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tla_pkg::*;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_PCT = 38;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_command = CMD_WRITE;
    logic [5:0] s_col = '0;
    logic [5:0] s_row = '0;
    logic       s_cell_in = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_cell_out;
    logic       m_done_res;

    class life_scoreboard;
        typedef struct packed {
            logic cell_out;
            logic done_res;
        } life_result_t;

        bit           cells [GRID_H][GRID_W];
        life_result_t expected_q[$];
        int n_errors;
        int n_writes;
        int n_reads;
        int n_live_reads;
        int n_steps;
        int n_unused;

        function new();
            foreach (cells[r, c]) cells[r][c] = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // whole next generation from the old grid, then swap in
        function void evolve_grid();
            bit nxt [GRID_H][GRID_W];
            int n, rr, cc;
            for (int r = 0; r < GRID_H; r++) begin
                for (int c = 0; c < GRID_W; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                rr = (r + dr + GRID_H) % GRID_H;
                                cc = (c + dc + GRID_W) % GRID_W;
                                n += cells[rr][cc];
                            end
                        end
                    end
                    if (cells[r][c])
                        nxt[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
                    else
                        nxt[r][c] = (n == BIRTH_COUNT);
                end
            end
            cells = nxt;
        endfunction

        function void note_command(logic [1:0] cmd, logic [5:0] col, logic [5:0] row,
                                   logic cell_in);
            life_result_t res;
            bit on_grid;
            on_grid = (int'(col) < GRID_W) && (int'(row) < GRID_H);
            res = '{cell_out: 1'b0, done_res: 1'b1};
            case (cmd)
                CMD_WRITE: begin
                    n_writes++;
                    if (on_grid) cells[row][col] = cell_in;
                end
                CMD_READ: begin
                    n_reads++;
                    if (on_grid) res.cell_out = cells[row][col];
                    if (res.cell_out) n_live_reads++;
                end
                CMD_STEP: begin
                    n_steps++;
                    evolve_grid();
                end
                default: begin
                    n_unused++;
                    res.done_res = 1'b0;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            n_errors++;
            if (n_errors <= MAX_PRINTED)
                $display("[%0t] error: %s", $realtime, what);
        endtask

        task check_result(logic cell_out, logic done_res);
            life_result_t exp_res;
            if (expected_q.size() == 0) begin
                report_mismatch("result transfer with no command pending");
            end else begin
                exp_res = expected_q.pop_front();
                if (cell_out !== exp_res.cell_out)
                    report_mismatch($sformatf("cell_out %b, expected %b",
                                              cell_out, exp_res.cell_out));
                if (done_res !== exp_res.done_res)
                    report_mismatch($sformatf("done_res %b, expected %b",
                                              done_res, exp_res.done_res));
            end
        endtask
    endclass

    life_scoreboard sb = new();

    bit quiet = 1'b0;       // no idling on either side while set
    bit hold_req = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;

    toroidal_life_automaton #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_col      (s_col),
        .s_row      (s_row),
        .s_cell_in  (s_cell_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out),
        .m_done_res (m_done_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // entered right after a rising edge, returns right after the transfer edge
    task automatic send_command(input logic [1:0] cmd, input logic [5:0] col,
                                input logic [5:0] row, input logic cell_in);
        @(negedge aclk);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_col     <= col;
        s_row     <= row;
        s_cell_in <= cell_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(cmd, col, row, cell_in);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_cell_out, m_done_res);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("toroidal_life_automaton: mismatch");
            $finish;
        end
    end

    initial begin
        int items;
        int n_wr, n_rd;
        bit held;
        logic [5:0] win_col, win_row;
        logic [1:0] cmd;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners, unused code, ignored fields
        send_command(CMD_READ,   6'd0,  6'd0,  1'b1);
        send_command(CMD_WRITE,  6'd0,  6'd0,  1'b1);
        send_command(CMD_WRITE,  6'd63, 6'd63, 1'b1);
        send_command(CMD_READ,   6'd63, 6'd63, 1'b0);
        send_command(CMD_READ,   6'd0,  6'd0,  1'b0);
        send_command(CMD_UNUSED, 6'd63, 6'd63, 1'b0);
        send_command(CMD_READ,   6'd63, 6'd63, 1'b1);
        send_command(CMD_WRITE,  6'd63, 6'd63, 1'b0);
        send_command(CMD_READ,   6'd63, 6'd63, 1'b1);
        // horizontal blinker across the column wrap on row 0
        send_command(CMD_WRITE,  6'd63, 6'd0,  1'b1);
        send_command(CMD_WRITE,  6'd1,  6'd0,  1'b1);
        send_command(CMD_STEP,   6'd63, 6'd63, 1'b1);
        // now vertical across the row wrap
        send_command(CMD_READ,   6'd0,  6'd63, 1'b0);
        send_command(CMD_READ,   6'd0,  6'd1,  1'b0);
        send_command(CMD_READ,   6'd63, 6'd0,  1'b0);
        send_command(CMD_STEP,   6'd0,  6'd0,  1'b0);
        send_command(CMD_READ,   6'd63, 6'd0,  1'b1);
        send_command(CMD_READ,   6'd0,  6'd63, 1'b1);
        send_command(CMD_UNUSED, 6'd0,  6'd0,  1'b1);

        items = 0;
        held  = 1'b0;
        while (items < RANDOM_ITEMS) begin
            quiet = (items >= 200 && items < 320);
            if (!held && items >= 400) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise: any fields, unused code included
                cmd = 2'($urandom_range(0, 3));
                send_command(cmd, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             1'($urandom_range(0, 1)));
                if (cmd != CMD_UNUSED) items++;
            end else begin
                // seed a small window, evolve it, read it back
                win_col = 6'($urandom_range(0, 63));
                win_row = 6'($urandom_range(0, 63));
                n_wr = $urandom_range(6, 24);
                for (int i = 0; i < n_wr; i++)
                    send_command(CMD_WRITE, 6'(win_col + $urandom_range(0, 7)),
                                 6'(win_row + $urandom_range(0, 7)),
                                 1'($urandom_range(0, 9) < 7));
                for (int i = $urandom_range(1, 3); i > 0; i--) begin
                    send_command(CMD_STEP, 6'($urandom_range(0, 63)),
                                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                    items++;
                end
                n_rd = $urandom_range(6, 16);
                for (int i = 0; i < n_rd; i++)
                    send_command(CMD_READ, 6'(win_col + $urandom_range(0, 9) - 1),
                                 6'(win_row + $urandom_range(0, 9) - 1),
                                 1'($urandom_range(0, 1)));
                items += n_wr + n_rd;
            end
        end
        quiet = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d writes, %0d reads (%0d live), %0d generations, %0d unused codes",
                 sb.n_writes, sb.n_reads, sb.n_live_reads, sb.n_steps, sb.n_unused);
        $display("%0d field mismatches", sb.n_errors);
        if (sb.n_errors == 0)
            $display("toroidal_life_automaton: match");
        else
            $display("toroidal_life_automaton: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

@@ toroidal_life_automaton.f @@
+incdir+rtl
rtl/tla_pkg.sv
rtl/tla_ram.sv
rtl/tla_cell.sv
rtl/toroidal_life_automaton.sv
test/tb_top.sv
